// ===== hdl/mfh_pkg.sv =====
// Shared types and constants for the MQTT fixed-header framer.
// Used by mfh_front, mfh_parser, mfh_result_q and mqtt_fixed_header_framer.
package mfh_pkg;

    localparam int LEN_W = 28;
    localparam int HDR_W = 3;
    localparam int CNT_W = 3;

    // Queue depth between stages; must be a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Packet type codes
    localparam logic [3:0] PT_CONNECT     = 4'd1;
    localparam logic [3:0] PT_PUBLISH     = 4'd3;
    localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
    localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] PT_PINGREQ     = 4'd12;
    localparam logic [3:0] PT_DISCONNECT  = 4'd14;

    // Minimum remaining lengths
    localparam logic [LEN_W-1:0] MIN_CONNECT     = LEN_W'(13);
    localparam logic [LEN_W-1:0] MIN_PUBLISH     = LEN_W'(3);
    localparam logic [LEN_W-1:0] MIN_SUBSCRIBE   = LEN_W'(6);
    localparam logic [LEN_W-1:0] MIN_UNSUBSCRIBE = LEN_W'(5);

    localparam logic [3:0] FLAGS_SUB  = 4'd2;
    localparam logic [3:0] PUB_QOS_MASK = 4'h0e;

    // Highest length byte count; a continuation bit here is an encoding error
    localparam logic [CNT_W-1:0] LEN_BYTES_MAX = CNT_W'(4);

    typedef enum logic [2:0] {
        V_OK     = 3'd0,
        V_BADLEN = 3'd1,
        V_TOOBIG = 3'd2,
        V_BADHDR = 3'd3,
        V_DISC   = 3'd4
    } t_verdict;

    // Stream byte split into its header views
    typedef struct packed {
        logic [3:0] hi_nibble;
        logic [3:0] lo_nibble;
        logic       cont;
        logic [6:0] group;
    } t_byte_info;

    typedef struct packed {
        logic [3:0]       packet_type;
        logic [3:0]       packet_flags;
        logic [LEN_W-1:0] rem_len;
        logic [HDR_W-1:0] header_bytes;
        t_verdict         verdict;
    } t_result;

endpackage

// ===== hdl/mqtt_fixed_header_framer.sv =====
// MQTT 3.1.1 fixed-header framer top level.
// Depends on mfh_pkg, mfh_front, mfh_parser and mfh_result_q.
//
// Usage:
//   Input side is a queue: drive i_stream_byte and raise push; the request is
//   taken at a clock edge where full is low. Results come out of a queue: while
//   empty is low the oldest verdict is on o_packet_type, o_packet_flags,
//   o_rem_len, o_header_bytes and o_verdict; raise pop to take it.
//   i_cfg_we writes i_cfg_wdata into the max length register; write it only
//   while the block is idle.
//   Throughput: one byte per cycle while the result queue has space, set by the
//   parser step between two 2-entry queues.
//   A verdict reaches the result ports after the byte that causes it is accepted
//   and has passed the front queue register, then the result queue write.
//   Reset (synchronous, active low) empties both queues, returns the parser to
//   the type byte, clears the connected flag and sets the max length to its
//   largest value.
//   When the receiver stalls, the result queue fills, the parser holds, and
//   full rises once the front queue has two bytes waiting.
module mqtt_fixed_header_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_cfg_we,
    input  logic [27:0] i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_packet_type,
    output logic [3:0]  o_packet_flags,
    output logic [27:0] o_rem_len,
    output logic [2:0]  o_header_bytes,
    output logic [2:0]  o_verdict
);
    import mfh_pkg::*;

    t_byte_info info;
    t_result    res_in, res_out;
    logic       f_valid, take, space, res_valid;

    mfh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_stream_byte (i_stream_byte),
        .o_valid       (f_valid),
        .i_take        (take),
        .o_info        (info)
    );

    mfh_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (f_valid),
        .i_info      (info),
        .o_take      (take),
        .i_space     (space),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    mfh_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_res   (res_in),
        .o_space (space),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_packet_type      = res_out.packet_type;
    assign o_packet_flags     = res_out.packet_flags;
    assign o_rem_len          = res_out.rem_len;
    assign o_header_bytes     = res_out.header_bytes;
    assign o_verdict          = res_out.verdict;

endmodule

// ===== hdl/mfh_front.sv =====
// Front stage: accepts stream bytes, splits them into header views and
// queues them for the parser. Depends on mfh_pkg.
module mfh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_stream_byte,
    output logic                o_valid,
    input  logic                i_take,
    output mfh_pkg::t_byte_info o_info
);
    import mfh_pkg::*;

    t_byte_info            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]       r_wp, r_rp;
    logic [Q_CW-1:0]       r_cnt;
    logic                  wr, rd;
    t_byte_info            info;

    assign full    = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_info  = r_mem[r_rp];
    assign wr      = push & ~full;
    assign rd      = i_take & o_valid;

    always_comb begin
        info.hi_nibble = i_stream_byte[7:4];
        info.lo_nibble = i_stream_byte[3:0];
        info.cont      = i_stream_byte[7];
        info.group     = i_stream_byte[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/mfh_parser.sv =====
// Back stage: fixed-header state machine, length decode, header checks and
// body count. Holds the max length register. Depends on mfh_pkg.
module mfh_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [27:0]         i_cfg_wdata,
    input  logic                i_valid,
    input  mfh_pkg::t_byte_info i_info,
    output logic                o_take,
    input  logic                i_space,
    output logic                o_res_valid,
    output mfh_pkg::t_result    o_res
);
    import mfh_pkg::*;

    typedef enum logic [3:0] {
        S_TYPE = 4'b0001,
        S_LEN  = 4'b0010,
        S_BODY = 4'b0100,
        S_DEAD = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_max, r_acc, n_acc, r_left, n_left;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]       r_type, n_type, r_flags, n_flags;
    logic             r_conn, n_conn;

    logic [LEN_W-1:0] shifted, acc_new;
    logic [CNT_W-1:0] cnt_new;
    logic             step, hdr_ok;

    function automatic logic header_ok(input logic [3:0] t, input logic [3:0] f,
                                       input logic [LEN_W-1:0] len, input logic conn);
        logic ok;
        ok = 1'b0;
        case (t)
            PT_CONNECT:     ok = (f == 4'd0) && (len >= MIN_CONNECT) && !conn;
            PT_PUBLISH:     ok = ((f & PUB_QOS_MASK) == 4'd0) && (len >= MIN_PUBLISH) && conn;
            PT_SUBSCRIBE:   ok = (f == FLAGS_SUB) && (len >= MIN_SUBSCRIBE) && conn;
            PT_UNSUBSCRIBE: ok = (f == FLAGS_SUB) && (len >= MIN_UNSUBSCRIBE) && conn;
            PT_PINGREQ:     ok = (f == 4'd0) && (len == '0) && conn;
            PT_DISCONNECT:  ok = (f == 4'd0) && (len == '0) && conn;
            default:        ok = 1'b0;
        endcase
        return ok;
    endfunction

    assign step   = i_valid & i_space;
    assign o_take = step;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    shifted = {21'd0, i_info.group};
            2'd1:    shifted = {14'd0, i_info.group, 7'd0};
            2'd2:    shifted = {7'd0, i_info.group, 14'd0};
            default: shifted = {i_info.group, 21'd0};
        endcase
        acc_new = r_acc | shifted;
        cnt_new = r_cnt + CNT_W'(1);
        hdr_ok  = header_ok(r_type, r_flags, acc_new, r_conn);
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_left  = r_left;
        n_cnt   = r_cnt;
        n_type  = r_type;
        n_flags = r_flags;
        n_conn  = r_conn;
        o_res_valid = 1'b0;
        o_res.packet_type      = r_type;
        o_res.packet_flags     = r_flags;
        o_res.rem_len          = r_acc;
        o_res.header_bytes     = r_cnt + HDR_W'(1);
        o_res.verdict          = V_OK;
        if (step) begin
            case (r_state)
                S_TYPE: begin
                    n_type  = i_info.hi_nibble;
                    n_flags = i_info.lo_nibble;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_left  = '0;
                    n_state = S_LEN;
                end
                S_LEN: begin
                    n_acc = acc_new;
                    n_cnt = cnt_new;
                    o_res.rem_len          = acc_new;
                    o_res.header_bytes     = cnt_new + HDR_W'(1);
                    if (i_info.cont) begin
                        if (cnt_new >= LEN_BYTES_MAX) begin
                            n_state = S_DEAD;
                            o_res_valid = 1'b1;
                            o_res.rem_len = '0;
                            o_res.verdict = V_BADLEN;
                        end
                    end else if (acc_new > r_max) begin
                        n_state = S_DEAD;
                        o_res_valid = 1'b1;
                        o_res.verdict = V_TOOBIG;
                    end else if (!hdr_ok) begin
                        n_state = S_DEAD;
                        o_res_valid = 1'b1;
                        o_res.verdict = V_BADHDR;
                    end else if (acc_new == '0) begin
                        // empty body: finish now
                        o_res_valid = 1'b1;
                        if (r_type == PT_DISCONNECT) begin
                            n_state = S_DEAD;
                            o_res.verdict = V_DISC;
                        end else begin
                            n_state = S_TYPE;
                            if (r_type == PT_CONNECT) begin
                                n_conn = 1'b1;
                            end
                        end
                    end else begin
                        n_left  = acc_new;
                        n_state = S_BODY;
                    end
                end
                S_BODY: begin
                    n_left = r_left - LEN_W'(1);
                    if (r_left == LEN_W'(1)) begin
                        // only accepted non-empty packets reach here; no disconnect
                        o_res_valid = 1'b1;
                        n_state = S_TYPE;
                        if (r_type == PT_CONNECT) begin
                            n_conn = 1'b1;
                        end
                    end
                end
                S_DEAD: begin
                    n_state = S_DEAD;
                end
                default: begin
                    n_state = S_DEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TYPE;
            r_max   <= LEN_MAX;
            r_acc   <= '0;
            r_left  <= '0;
            r_cnt   <= '0;
            r_type  <= '0;
            r_flags <= '0;
            r_conn  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_state <= n_state;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
            r_type  <= n_type;
            r_flags <= n_flags;
            r_conn  <= n_conn;
        end
    end

endmodule

// ===== hdl/mfh_result_q.sv =====
// Result queue: holds verdicts until the receiver pops them.
// Depends on mfh_pkg.
module mfh_result_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  mfh_pkg::t_result i_res,
    output logic             o_space,
    output logic             empty,
    input  logic             pop,
    output mfh_pkg::t_result o_res
);
    import mfh_pkg::*;

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            rd, wr;

    assign empty   = (r_cnt == '0);
    assign rd      = pop & ~empty;
    // a pop this cycle frees an entry for the parser
    assign o_space = (r_cnt != Q_CW'(Q_DEPTH)) | rd;
    assign wr      = i_wr & o_space;
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sim/mfh_verdict_checker.sv =====
`timescale 1ns / 1ps
// Verdict checker for the MQTT fixed-header framer testbench.
// Tracks the byte stream and config writes, predicts each verdict and compares it
// with what the framer pops out. Depends on mfh_pkg.
module mfh_verdict_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  logic                      full,
    input  logic [7:0]                i_stream_byte,
    input  logic                      i_cfg_we,
    input  logic [mfh_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [3:0]                i_packet_type,
    input  logic [3:0]                i_packet_flags,
    input  logic [mfh_pkg::LEN_W-1:0] i_rem_len,
    input  logic [mfh_pkg::HDR_W-1:0] i_header_bytes,
    input  logic [2:0]                i_verdict,
    output int                        o_errors,
    output logic                      o_waiting
);
    import mfh_pkg::*;

    typedef enum logic [3:0] {
        PH_TYPE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DEAD = 4'b1000
    } t_frame_phase;

    t_frame_phase     phase;
    logic [LEN_W-1:0] len_acc;
    logic [CNT_W-1:0] len_cnt;
    logic [LEN_W-1:0] body_left;
    logic [3:0]       hold_type;
    logic [3:0]       hold_flags;
    logic             connected;
    logic [LEN_W-1:0] max_len;

    t_result verdict_q[$];

    initial begin
        o_errors  = 0;
        o_waiting = 1'b0;
    end

    function automatic logic header_legal(input logic [3:0] t, input logic [3:0] f,
                                          input logic [LEN_W-1:0] rlen);
        case (t)
            PT_CONNECT:     return f == 4'd0 && rlen >= MIN_CONNECT && !connected;
            PT_PUBLISH:     return (f & PUB_QOS_MASK) == 4'd0 && rlen >= MIN_PUBLISH
                                   && connected;
            PT_SUBSCRIBE:   return f == FLAGS_SUB && rlen >= MIN_SUBSCRIBE && connected;
            PT_UNSUBSCRIBE: return f == FLAGS_SUB && rlen >= MIN_UNSUBSCRIBE && connected;
            PT_PINGREQ,
            PT_DISCONNECT:  return f == 4'd0 && rlen == '0 && connected;
            default:        return 1'b0;
        endcase
    endfunction

    // Close an accepted packet: a disconnect kills the stream, a connect logs in.
    function automatic t_verdict close_packet();
        if (hold_type == PT_DISCONNECT) begin
            phase = PH_DEAD;
            return V_DISC;
        end
        if (hold_type == PT_CONNECT)
            connected = 1'b1;
        phase = PH_TYPE;
        return V_OK;
    endfunction

    task automatic queue_verdict(input logic [LEN_W-1:0] rlen, input logic [HDR_W-1:0] hb,
                                 input t_verdict v);
        t_result r;
        r.packet_type      = hold_type;
        r.packet_flags     = hold_flags;
        r.rem_len          = rlen;
        r.header_bytes     = hb;
        r.verdict          = v;
        verdict_q.push_back(r);
    endtask

    task automatic frame_byte(input logic [7:0] b);
        logic [HDR_W-1:0] hb;
        case (phase)
            PH_TYPE: begin
                hold_type  = b[7:4];
                hold_flags = b[3:0];
                len_acc    = '0;
                len_cnt    = '0;
                body_left  = '0;
                phase      = PH_LEN;
            end
            PH_LEN: begin
                len_acc = len_acc | (LEN_W'(b[6:0]) << (7 * len_cnt[1:0]));
                len_cnt = len_cnt + 1'b1;
                hb      = HDR_W'(len_cnt) + 1'b1;
                if (b[7]) begin
                    if (len_cnt >= LEN_BYTES_MAX) begin
                        phase = PH_DEAD;
                        queue_verdict('0, hb, V_BADLEN);
                    end
                end else if (len_acc > max_len) begin
                    phase = PH_DEAD;
                    queue_verdict(len_acc, hb, V_TOOBIG);
                end else if (!header_legal(hold_type, hold_flags, len_acc)) begin
                    phase = PH_DEAD;
                    queue_verdict(len_acc, hb, V_BADHDR);
                end else if (len_acc == '0) begin
                    queue_verdict('0, hb, close_packet());
                end else begin
                    body_left = len_acc;
                    phase     = PH_BODY;
                end
            end
            PH_BODY: begin
                if (body_left != '0)
                    body_left = body_left - 1'b1;
                if (body_left == '0)
                    queue_verdict(len_acc, HDR_W'(len_cnt) + 1'b1, close_packet());
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            phase      = PH_TYPE;
            len_acc    = '0;
            len_cnt    = '0;
            body_left  = '0;
            hold_type  = '0;
            hold_flags = '0;
            connected  = 1'b0;
            max_len    = LEN_MAX;
            verdict_q.delete();
        end else begin
            if (i_cfg_we)
                max_len = i_cfg_wdata;

            if (pop && !empty) begin
                got.packet_type      = i_packet_type;
                got.packet_flags     = i_packet_flags;
                got.rem_len          = i_rem_len;
                got.header_bytes     = i_header_bytes;
                got.verdict          = t_verdict'(i_verdict);
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, actual %p", $time, got);
                    o_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.packet_type !== want.packet_type) begin
                        $display("%0t: packet_type expected %0d actual %0d", $time,
                                 want.packet_type, got.packet_type);
                        o_errors++;
                    end
                    if (got.packet_flags !== want.packet_flags) begin
                        $display("%0t: packet_flags expected %0d actual %0d", $time,
                                 want.packet_flags, got.packet_flags);
                        o_errors++;
                    end
                    if (got.rem_len !== want.rem_len) begin
                        $display("%0t: rem_len expected %0d actual %0d", $time,
                                 want.rem_len, got.rem_len);
                        o_errors++;
                    end
                    if (got.header_bytes !== want.header_bytes) begin
                        $display("%0t: header_bytes expected %0d actual %0d", $time,
                                 want.header_bytes, got.header_bytes);
                        o_errors++;
                    end
                    if (got.verdict !== want.verdict) begin
                        $display("%0t: verdict expected %0d actual %0d", $time,
                                 want.verdict, got.verdict);
                        o_errors++;
                    end
                end
            end

            if (push && !full)
                frame_byte(i_stream_byte);
        end
        o_waiting <= (verdict_q.size() != 0);
    end

endmodule

// ===== sim/mqtt_fixed_header_framer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for mqtt_fixed_header_framer: clock, reset, byte stream and
// config stimulus, and the final verdict. Depends on mfh_pkg and mfh_verdict_checker.
module mqtt_fixed_header_framer_tb;
    import mfh_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int unsigned LIMIT_CYCLES = 200_000;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             push          = 1'b0;
    logic [7:0]       i_stream_byte = 8'h00;
    logic             i_cfg_we      = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata   = '0;
    logic             pop           = 1'b0;
    logic             full;
    logic             empty;
    logic [3:0]       o_packet_type;
    logic [3:0]       o_packet_flags;
    logic [LEN_W-1:0] o_rem_len;
    logic [HDR_W-1:0] o_header_bytes;
    logic [2:0]       o_verdict;

    int               errors;
    logic             waiting;
    logic             calm = 1'b0;
    int unsigned      bytes_sent = 0;
    logic [LEN_W-1:0] cur_max = LEN_MAX;

    always #CLK_HALF i_clk = ~i_clk;

    mqtt_fixed_header_framer uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_stream_byte      (i_stream_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .empty              (empty),
        .pop                (pop),
        .o_packet_type      (o_packet_type),
        .o_packet_flags     (o_packet_flags),
        .o_rem_len          (o_rem_len),
        .o_header_bytes     (o_header_bytes),
        .o_verdict          (o_verdict)
    );

    mfh_verdict_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_stream_byte      (i_stream_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .empty              (empty),
        .pop                (pop),
        .i_packet_type      (o_packet_type),
        .i_packet_flags     (o_packet_flags),
        .i_rem_len          (o_rem_len),
        .i_header_bytes     (o_header_bytes),
        .i_verdict          (o_verdict),
        .o_errors           (errors),
        .o_waiting          (waiting)
    );

    // Receiver: stall on about ten percent of clock edges, never while calm.
    always @(posedge i_clk)
        pop <= calm || ($urandom_range(99) >= 10);

    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 4) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_stream_byte <= b;
        calm          <= (bytes_sent >= 250 && bytes_sent < 420);
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    // Hold the sender until every verdict is out and the pipeline is quiet.
    task automatic drain_verdicts();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [LEN_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_max = v;
    endtask

    // Type byte plus remaining length, padded with extra continuation groups.
    task automatic send_header(input logic [3:0] t, input logic [3:0] f,
                               input logic [LEN_W-1:0] rlen, input int unsigned pad);
        int unsigned n;
        int unsigned total;
        n = 1;
        while (n < 4 && (rlen >> (7 * n)) != 0)
            n++;
        total = (n + pad > 4) ? 4 : n + pad;
        push_byte({t, f});
        for (int unsigned i = 0; i < total; i++)
            push_byte({i < total - 1, 7'(rlen >> (7 * i))});
    endtask

    task automatic send_body(input int unsigned n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int unsigned random_pad();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // One well-formed request of a connected client that fits the current max.
    task automatic send_session_packet();
        int unsigned kind;
        logic [3:0]  t;
        logic [3:0]  f;
        int unsigned lo;
        int unsigned rlen;
        kind = $urandom_range(0, 9);
        if (kind <= 4) begin
            t  = PT_PUBLISH;
            f  = {3'b000, 1'($urandom_range(0, 1))};
            lo = 32'(MIN_PUBLISH);
        end else if (kind <= 6) begin
            t  = PT_SUBSCRIBE;
            f  = FLAGS_SUB;
            lo = 32'(MIN_SUBSCRIBE);
        end else if (kind <= 8) begin
            t  = PT_UNSUBSCRIBE;
            f  = FLAGS_SUB;
            lo = 32'(MIN_UNSUBSCRIBE);
        end else begin
            t  = PT_PINGREQ;
            f  = 4'd0;
            lo = 0;
        end
        if (lo > cur_max) begin
            t  = PT_PINGREQ;
            f  = 4'd0;
            lo = 0;
        end
        if (t == PT_PINGREQ)
            rlen = 0;
        else begin
            rlen = lo + (($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(0, 16));
            if (rlen > cur_max)
                rlen = 32'(cur_max);
        end
        send_header(t, f, LEN_W'(rlen), random_pad());
        send_body(rlen);
    endtask

    task automatic run_session(input int unsigned upto);
        while (bytes_sent < upto)
            send_session_packet();
    endtask

    initial begin
        int unsigned      end_case;
        int unsigned      sub;
        logic [3:0]       t;
        logic [3:0]       f;
        logic [LEN_W-1:0] m;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_max(LEN_MAX);

        // Shortest connect with extreme body bytes, a publish with a four-byte
        // length, then a ping.
        send_header(PT_CONNECT, 4'd0, MIN_CONNECT, 0);
        for (int i = 0; i < 13; i++)
            push_byte((i % 2) ? 8'hFF : 8'h00);
        send_header(PT_PUBLISH, 4'd1, MIN_PUBLISH, 3);
        send_body(MIN_PUBLISH);
        send_header(PT_PINGREQ, 4'd0, '0, 0);

        run_session(200);
        drain_verdicts();
        run_session(350);
        drain_verdicts();

        write_max(LEN_W'($urandom_range(6, 30)));
        run_session(550);
        drain_verdicts();

        // Zero max: only empty-body requests get through.
        write_max('0);
        repeat (20) send_session_packet();
        drain_verdicts();

        write_max(LEN_W'($urandom_range(13, 4096)));
        run_session(830);
        drain_verdicts();

        // One fatal request ends the stream.
        end_case = $urandom_range(0, 3);
        if (end_case == 1) begin
            m = LEN_W'($urandom_range(0, 1000));
            write_max(m);
        end else
            write_max(LEN_MAX);

        case (end_case)
            0: begin
                push_byte(8'($urandom_range(0, 255)));
                repeat (4) push_byte({1'b1, 7'($urandom_range(0, 127))});
            end
            1: begin
                send_header(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            LEN_W'($urandom_range(m + 1, LEN_MAX)), random_pad());
            end
            2: begin
                sub = $urandom_range(0, 4);
                case (sub)
                    0: send_header(PT_CONNECT, 4'd0, MIN_CONNECT, 0);
                    1: begin
                        do t = 4'($urandom_range(0, 15));
                        while (t inside {PT_CONNECT, PT_PUBLISH, PT_SUBSCRIBE,
                                         PT_UNSUBSCRIBE, PT_PINGREQ, PT_DISCONNECT});
                        send_header(t, 4'($urandom_range(0, 15)),
                                    LEN_W'($urandom_range(0, 20)), random_pad());
                    end
                    2: begin
                        do f = 4'($urandom_range(0, 15)); while (f == FLAGS_SUB);
                        send_header(PT_SUBSCRIBE, f, MIN_SUBSCRIBE, 0);
                    end
                    3: send_header(PT_PUBLISH, {3'($urandom_range(1, 7)),
                                   1'($urandom_range(0, 1))}, MIN_PUBLISH, 0);
                    default: begin
                        if ($urandom_range(0, 1))
                            send_header(PT_PUBLISH, 4'd0,
                                        LEN_W'($urandom_range(0, 2)), random_pad());
                        else
                            send_header(PT_PINGREQ, 4'd0,
                                        LEN_W'($urandom_range(1, 5)), random_pad());
                    end
                endcase
            end
            default: send_header(PT_DISCONNECT, 4'd0, '0, random_pad());
        endcase

        // The stream is dead now; these bytes must be dropped.
        send_body(16);
        drain_verdicts();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(CLK_HALF * 2 * LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
